/* rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// needs clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk_i) prop) \
  else $error("assertion failed");
`else
`define ASSERT_RST(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* rtl/dpt_pkg.sv */
// shared constants and types of the dual pi thrust controller
// no dependencies
package dpt_pkg;

  localparam int INTEGRAL_WIDTH_DEF = 32;

  localparam int VAL_W     = 16;
  localparam int ERR_W     = 17;
  localparam int GAIN_W    = 16;
  localparam int U_W       = 44;
  localparam int MIX_W     = 62;
  localparam int QUOT_W    = 15;
  localparam int THR_W     = 16;
  localparam int CNT_W     = 5;
  localparam int MUL_STEPS = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [THR_W-1:0] THRUST_ONE = 16'sd16384;

  localparam logic [GAIN_W-1:0] HALF_TRACK_RST = 16'd256;
  localparam logic [GAIN_W-1:0] COEF_RST       = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_LINEAR  = 3'd0,
    CFG_KI_LINEAR  = 3'd1,
    CFG_KP_ANGULAR = 3'd2,
    CFG_KI_ANGULAR = 3'd3,
    CFG_HALF_TRACK = 3'd4,
    CFG_LEFT_COEF  = 3'd5,
    CFG_RIGHT_COEF = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_linear;
    logic [GAIN_W-1:0] ki_linear;
    logic [GAIN_W-1:0] kp_angular;
    logic [GAIN_W-1:0] ki_angular;
    logic [GAIN_W-1:0] half_track;
    logic [GAIN_W-1:0] left_coef;
    logic [GAIN_W-1:0] right_coef;
  } cfg_t;

  typedef enum logic [0:0] {
    UOP_MUL = 1'b0,
    UOP_DIV = 1'b1
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* rtl/dpt_in_if.sv */
// input item channel of the thrust controller
// uses dpt_pkg
interface dpt_in_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic signed [dpt_pkg::VAL_W-1:0]   target_linear;
  logic signed [dpt_pkg::VAL_W-1:0]   measured_linear;
  logic signed [dpt_pkg::VAL_W-1:0]   target_angular;
  logic signed [dpt_pkg::VAL_W-1:0]   measured_angular;

  modport source (
    output valid, op, target_linear, measured_linear, target_angular, measured_angular,
    input  ready
  );
  modport sink (
    input  valid, op, target_linear, measured_linear, target_angular, measured_angular,
    output ready
  );
endinterface

/* rtl/dpt_out_if.sv */
// result item channel of the thrust controller
// uses dpt_pkg
interface dpt_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [dpt_pkg::THR_W-1:0] left_thrust;
  logic signed [dpt_pkg::THR_W-1:0] right_thrust;
  logic [1:0]                       clamped;

  modport source (output valid, left_thrust, right_thrust, clamped, input ready);
  modport sink (input valid, left_thrust, right_thrust, clamped, output ready);
endinterface

/* rtl/dpt_cfg_if.sv */
// configuration write channel of the thrust controller
// uses dpt_pkg
interface dpt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dpt_pkg::CFG_IDX_W-1:0]     index;
  logic [dpt_pkg::GAIN_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/dpt_cfg_regs.sv */
// gain, track and thruster coefficient registers
// uses dpt_pkg and dpt_cfg_if
module dpt_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  dpt_cfg_if.sink       cfg_i,
  output dpt_pkg::cfg_t regs_o
);

  dpt_pkg::cfg_t regs_q, regs_d;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      unique case (dpt_pkg::cfg_idx_e'(cfg_i.index))
        dpt_pkg::CFG_KP_LINEAR:  regs_d.kp_linear  = cfg_i.data;
        dpt_pkg::CFG_KI_LINEAR:  regs_d.ki_linear  = cfg_i.data;
        dpt_pkg::CFG_KP_ANGULAR: regs_d.kp_angular = cfg_i.data;
        dpt_pkg::CFG_KI_ANGULAR: regs_d.ki_angular = cfg_i.data;
        dpt_pkg::CFG_HALF_TRACK: regs_d.half_track = cfg_i.data;
        dpt_pkg::CFG_LEFT_COEF:  regs_d.left_coef  = cfg_i.data;
        dpt_pkg::CFG_RIGHT_COEF: regs_d.right_coef = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.kp_linear  <= '0;
      regs_q.ki_linear  <= '0;
      regs_q.kp_angular <= '0;
      regs_q.ki_angular <= '0;
      regs_q.half_track <= dpt_pkg::HALF_TRACK_RST;
      regs_q.left_coef  <= dpt_pkg::COEF_RST;
      regs_q.right_coef <= dpt_pkg::COEF_RST;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

/* rtl/dpt_shared_unit.sv */
// shared shift-add multiplier and restoring divider, one add per cycle
// uses dpt_pkg and assert_macros.svh
`include "assert_macros.svh"
module dpt_shared_unit #(
  parameter int AW = dpt_pkg::MIX_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dpt_pkg::unit_cmd_t            cmd_i,
  input  logic [AW-1:0]                 init_i,
  input  logic [AW-1:0]                 a_i,
  input  logic [dpt_pkg::GAIN_W-1:0]    b_i,
  output dpt_pkg::unit_stat_t           stat_o,
  output logic [AW-1:0]                 acc_o,
  output logic [dpt_pkg::QUOT_W-1:0]    quot_o
);

  localparam int CW = dpt_pkg::CNT_W;
  localparam int QW = dpt_pkg::QUOT_W;
  localparam logic [QW-1:0] QMAX = QW'(dpt_pkg::THRUST_ONE);

  logic [AW-1:0]                 acc_q, acc_d, a_q, a_d, y, sum;
  logic [dpt_pkg::GAIN_W-1:0]    b_q, b_d;
  logic [QW-1:0]                 q_q, q_d;
  dpt_pkg::unit_op_e             op_q, op_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic                          busy_q, busy_d, done_q, done_d;
  logic                          is_div;

  assign is_div = (op_q == dpt_pkg::UOP_DIV);
  // the one adder: acc + a for multiply, acc - a for divide
  assign y      = is_div ? ~a_q : a_q;
  assign sum    = acc_q + y + {{(AW-1){1'b0}}, is_div};

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    q_d    = q_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      acc_d  = init_i;
      a_d    = (cmd_i.op == dpt_pkg::UOP_DIV) ? (a_i << (QW - 1)) : a_i;
      b_d    = b_i;
      q_d    = '0;
      op_d   = cmd_i.op;
      cnt_d  = (cmd_i.op == dpt_pkg::UOP_DIV) ? CW'(QW) : CW'(dpt_pkg::MUL_STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      cnt_d = cnt_q - CW'(1);
      if (is_div) begin
        // restoring step: keep the difference when it stays non-negative
        if (!sum[AW-1]) begin
          acc_d = sum;
        end
        q_d = {q_q[QW-2:0], ~sum[AW-1]};
        a_d = a_q >> 1;
      end else begin
        if (b_q[0]) begin
          acc_d = sum;
        end
        a_d = a_q << 1;
        b_d = b_q >> 1;
      end
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= dpt_pkg::UOP_MUL;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      op_q   <= op_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    q_q   <= q_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign acc_o       = acc_q;
  assign quot_o      = q_q;

  `ASSERT_RST(a_start_when_free, cmd_i.start |-> !busy_q)
  `ASSERT_RST(a_done_after_busy, done_q |-> ($past(busy_q) && !busy_q))
  `ASSERT_RST(a_quot_in_range, (done_q && is_div) |-> (q_q <= QMAX))

endmodule

/* rtl/dual_pi_differential_thrust_core.sv */
// dual pi velocity controller with differential thrust mixer, top level
// each control item runs five 16-step shift-add products and two 15-step divides on one
// adder, skipping the divide of a side that clamps; the next item is taken only once the
// previous result has entered the output register, once the one before it has been taken
// a clear item zeroes both integrators; reset clears integrators, state and output valid at once
// uses dpt_pkg, the channel interfaces, dpt_cfg_regs, dpt_shared_unit, assert_macros.svh
`include "assert_macros.svh"
module dual_pi_differential_thrust_core #(
  parameter int INTEGRAL_WIDTH = dpt_pkg::INTEGRAL_WIDTH_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  dpt_cfg_if.sink   cfg_i,
  dpt_in_if.sink    in_i,
  dpt_out_if.source out_o
);

  localparam int IW   = INTEGRAL_WIDTH;
  localparam int MW   = dpt_pkg::MIX_W;
  localparam int UW   = dpt_pkg::U_W;
  localparam int EW   = dpt_pkg::ERR_W;
  localparam int TW   = dpt_pkg::THR_W;
  localparam int AW   = (IW + 18 > MW) ? IW + 18 : MW;
  localparam logic signed [TW-1:0] T_POS = dpt_pkg::THRUST_ONE;
  localparam logic signed [TW-1:0] T_NEG = -dpt_pkg::THRUST_ONE;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    STEP_P_LIN = 3'd0,
    STEP_I_LIN = 3'd1,
    STEP_P_ANG = 3'd2,
    STEP_I_ANG = 3'd3,
    STEP_MIX   = 3'd4,
    STEP_DIV_L = 3'd5,
    STEP_DIV_R = 3'd6
  } step_e;

  function automatic logic signed [IW-1:0] sat_int(logic signed [IW-1:0] s,
                                                   logic signed [EW-1:0] e);
    logic signed [IW:0] r;
    r = $signed({s[IW-1], s}) + (IW+1)'(e);
    if (r[IW] != r[IW-1]) begin
      return r[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end
    return r[IW-1:0];
  endfunction

  function automatic logic signed [UW-1:0] sat_u(logic [AW-1:0] v);
    if (v[AW-1:UW-1] == {(AW-UW+1){v[AW-1]}}) begin
      return v[UW-1:0];
    end
    return v[AW-1] ? {1'b1, {(UW-1){1'b0}}} : {1'b0, {(UW-1){1'b1}}};
  endfunction

  dpt_pkg::cfg_t       regs;
  dpt_pkg::unit_cmd_t  cmd;
  dpt_pkg::unit_stat_t stat;
  logic [AW-1:0]       u_init, u_a, u_acc;
  logic [dpt_pkg::GAIN_W-1:0] u_b;
  logic [dpt_pkg::QUOT_W-1:0] u_quot;

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic signed [EW-1:0] el_q, el_d, ea_q, ea_d, el_new, ea_new;
  logic signed [IW-1:0] sum_l_q, sum_l_d, sum_a_q, sum_a_d;
  logic signed [UW-1:0] ul_q, ul_d, ua_q, ua_d;
  logic signed [MW-1:0] ml_q, ml_d, mr_q, mr_d, m_cur;
  logic signed [TW-1:0] tl_q, tl_d, tr_q, tr_d, side_thr;
  logic                 cl_q, cl_d, cr_q, cr_d;
  logic                 out_valid_q, out_valid_d;
  logic signed [TW-1:0] ol_q, ol_d, or_q, or_d;
  logic [1:0]           oc_q, oc_d;

  logic [dpt_pkg::GAIN_W-1:0] coef_cur;
  logic [MW-1:0]        mag, lim;
  logic                 m_neg, over, need_div;
  logic [TW-1:0]        q_ext;
  logic                 in_acc;
  logic                 unit_start;

  dpt_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  dpt_shared_unit #(.AW(AW)) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .init_i (u_init),
    .a_i    (u_a),
    .b_i    (u_b),
    .stat_o (stat),
    .acc_o  (u_acc),
    .quot_o (u_quot)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && (state_q == ST_IDLE);

  assign el_new = $signed({in_i.target_linear[15], in_i.target_linear})
                - $signed({in_i.measured_linear[15], in_i.measured_linear});
  assign ea_new = $signed({in_i.target_angular[15], in_i.target_angular})
                - $signed({in_i.measured_angular[15], in_i.measured_angular});

  // per-side scaling: magnitude, clamp test and signed quotient
  assign m_cur    = (step_q == STEP_DIV_L) ? ml_q : mr_q;
  assign coef_cur = (step_q == STEP_DIV_L) ? regs.left_coef : regs.right_coef;
  assign m_neg    = m_cur[MW-1];
  assign mag      = m_neg ? -m_cur : m_cur;
  assign lim      = MW'({coef_cur, 16'h0000});
  assign over     = (mag > lim);
  assign need_div = !over && (coef_cur != '0);
  assign q_ext    = TW'(u_quot);
  assign side_thr = m_neg ? $signed(~q_ext + TW'(1)) : $signed(q_ext);

  // operands for the shared unit
  always_comb begin
    cmd.start = unit_start;
    cmd.op    = dpt_pkg::UOP_MUL;
    u_init    = '0;
    u_a       = '0;
    u_b       = '0;
    unique case (step_q)
      STEP_P_LIN: begin
        u_a = AW'(el_q);
        u_b = regs.kp_linear;
      end
      STEP_I_LIN: begin
        u_init = u_acc;
        u_a    = AW'(sum_l_q);
        u_b    = regs.ki_linear;
      end
      STEP_P_ANG: begin
        u_a = AW'(ea_q);
        u_b = regs.kp_angular;
      end
      STEP_I_ANG: begin
        u_init = u_acc;
        u_a    = AW'(sum_a_q);
        u_b    = regs.ki_angular;
      end
      STEP_MIX: begin
        // right side: ul*256 + half_track*ua
        u_init = AW'(ul_q) << 8;
        u_a    = AW'(ua_q);
        u_b    = regs.half_track;
      end
      STEP_DIV_L, STEP_DIV_R: begin
        cmd.op = dpt_pkg::UOP_DIV;
        u_init = AW'(mag);
        u_a    = AW'({coef_cur, 2'b00});
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    el_d        = el_q;
    ea_d        = ea_q;
    sum_l_d     = sum_l_q;
    sum_a_d     = sum_a_q;
    ul_d        = ul_q;
    ua_d        = ua_q;
    ml_d        = ml_q;
    mr_d        = mr_q;
    tl_d        = tl_q;
    tr_d        = tr_q;
    cl_d        = cl_q;
    cr_d        = cr_q;
    ol_d        = ol_q;
    or_d        = or_q;
    oc_d        = oc_q;
    unit_start  = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.op) begin
            sum_l_d = '0;
            sum_a_d = '0;
          end else begin
            el_d    = el_new;
            ea_d    = ea_new;
            sum_l_d = sat_int(sum_l_q, el_new);
            sum_a_d = sat_int(sum_a_q, ea_new);
            step_d  = STEP_P_LIN;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        if ((step_q == STEP_DIV_L || step_q == STEP_DIV_R) && !need_div) begin
          // clamped side, or zero coefficient with zero mix
          if (step_q == STEP_DIV_L) begin
            tl_d    = over ? (m_neg ? T_NEG : T_POS) : '0;
            cl_d    = over;
            step_d  = STEP_DIV_R;
          end else begin
            tr_d    = over ? (m_neg ? T_NEG : T_POS) : '0;
            cr_d    = over;
            state_d = ST_FINISH;
          end
        end else begin
          unit_start = 1'b1;
          state_d    = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (stat.done) begin
          state_d = ST_ISSUE;
          unique case (step_q)
            STEP_P_LIN: step_d = STEP_I_LIN;
            STEP_I_LIN: begin
              ul_d   = sat_u(u_acc);
              step_d = STEP_P_ANG;
            end
            STEP_P_ANG: step_d = STEP_I_ANG;
            STEP_I_ANG: begin
              ua_d   = sat_u(u_acc);
              step_d = STEP_MIX;
            end
            STEP_MIX: begin
              mr_d   = u_acc[MW-1:0];
              ml_d   = (MW'(ul_q) <<< 9) - $signed(u_acc[MW-1:0]);
              step_d = STEP_DIV_L;
            end
            STEP_DIV_L: begin
              tl_d   = side_thr;
              cl_d   = 1'b0;
              step_d = STEP_DIV_R;
            end
            STEP_DIV_R: begin
              tr_d    = side_thr;
              cr_d    = 1'b0;
              state_d = ST_FINISH;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          ol_d        = tl_q;
          or_d        = tr_q;
          oc_d        = {cr_q, cl_q};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_P_LIN;
      sum_l_q     <= '0;
      sum_a_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sum_l_q     <= sum_l_d;
      sum_a_q     <= sum_a_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    el_q <= el_d;
    ea_q <= ea_d;
    ul_q <= ul_d;
    ua_q <= ua_d;
    ml_q <= ml_d;
    mr_q <= mr_d;
    tl_q <= tl_d;
    tr_q <= tr_d;
    cl_q <= cl_d;
    cr_q <= cr_d;
    ol_q <= ol_d;
    or_q <= or_d;
    oc_q <= oc_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.left_thrust  = ol_q;
  assign out_o.right_thrust = or_q;
  assign out_o.clamped      = oc_q;

  `ASSERT_RST(a_out_from_finish, $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
  `ASSERT_RST(a_left_range, out_valid_q |-> (ol_q <= T_POS && ol_q >= T_NEG))
  `ASSERT_RST(a_left_clamp_full, (out_valid_q && oc_q[0]) |-> (ol_q == T_POS || ol_q == T_NEG))
  `ASSERT_RST(a_right_clamp_full, (out_valid_q && oc_q[1]) |-> (or_q == T_POS || or_q == T_NEG))

endmodule
